FILE: rtl/set_assoc_cache_lru_lookup_unit_assert.svh
// assertion macros used by the checker file of the lookup unit
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SACL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lookup unit check failed");

// antecedent implies consequent in the cycle after
`define SACL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lookup unit check failed");

`endif

FILE: rtl/sacl_pkg.sv
// types and constants of the set-associative lru lookup unit
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

    localparam int C_ADDR_W         = 32;
    localparam int C_BYTES_PER_WORD = 4;
    localparam int C_WORD_W         = C_ADDR_W - $clog2(C_BYTES_PER_WORD);
    localparam int C_TAG_W          = C_WORD_W;
    localparam int C_MAX_WAYS       = 8;
    localparam int C_WAY_W          = 3;
    localparam int C_WAYS_W         = 4;
    localparam int C_RANK_W         = 3;
    localparam int C_OUT_W          = 2;
    localparam int C_OUT_DATA_W     = 8;

    localparam logic [C_RANK_W-1:0] C_MAX_RANK = C_RANK_W'(C_MAX_WAYS - 1);

    // outcome codes
    localparam logic [C_OUT_W-1:0] C_OUT_HIT     = 2'd0;
    localparam logic [C_OUT_W-1:0] C_OUT_FILL    = 2'd1;
    localparam logic [C_OUT_W-1:0] C_OUT_REPLACE = 2'd2;

    // configuration register indexes
    localparam int C_CFG_IDX_W = 2;
    localparam int C_CFG_DATA_W = 4;
    localparam logic [C_CFG_IDX_W-1:0] C_CFG_SETS_LOG2   = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_CFG_BLOCK_WORDS = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_CFG_WAYS_USED   = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [C_TAG_W-1:0]  tag;
        logic [C_RANK_W-1:0] rank;
    } t_way_entry;

    typedef t_way_entry [C_MAX_WAYS-1:0] t_set_row;

    localparam int C_ROW_W = $bits(t_set_row);

    typedef struct packed {
        logic [C_OUT_W-1:0] outcome;
        logic [C_WAY_W-1:0] way;
    } t_lookup_res;

endpackage

`default_nettype wire

FILE: rtl/set_assoc_cache_lru_lookup_unit.sv
// a result is registered once its set row has been read and the output register is free
// one item at a time: the next is accepted only after the set row is read and written back
// the input is not ready while an item is in flight; a waiting result blocks write-back only
// reset: registers go to 6 / 2 / 8, per-set row valid flops clear so every set reads empty
// no clearing pass is needed, items are accepted from the first cycle after reset
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_lru_lookup_unit
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = 256
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // config write port
    input  wire logic                    i_cfg_we,
    input  wire logic [C_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [C_CFG_DATA_W-1:0] i_cfg_wdata,
    // address item in
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [C_ADDR_W-1:0]     i_s_tdata,   // [31:0] address
    // result item out
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [C_OUT_DATA_W-1:0]      o_m_tdata    // [1:0] outcome, [4:2] way_index, zero pad
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SETS_LG = $clog2(MAX_SETS + 1) - 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic                    r_state;
    logic                    n_state;
    logic [3:0]              r_sets_log2;
    logic [2:0]              r_block_words_log2;
    logic [C_WAYS_W-1:0]     r_ways_used;
    logic [MAX_SETS-1:0]     r_row_vld;
    logic                    r_row_live;
    logic [SET_W-1:0]        r_set;
    logic [C_TAG_W-1:0]      r_tag;
    logic                    r_m_valid;
    logic                    n_m_valid;
    t_lookup_res             r_res;

    logic                    accept;
    logic                    out_free;
    logic                    done;
    logic [3:0]              sets_eff;
    logic [C_WAYS_W-1:0]     ways_eff;
    logic [C_WORD_W-1:0]     word_addr;
    logic [C_WORD_W-1:0]     block_addr;
    logic [C_WORD_W-1:0]     set_mask;
    logic [SET_W-1:0]        set_idx;
    logic [C_TAG_W-1:0]      tag_val;
    logic [C_ROW_W-1:0]      ram_rdata;
    t_set_row                row_in;
    t_set_row                row_out;
    t_lookup_res             res;

    // handshake
    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;
    assign done       = (r_state == ST_LOOK) && out_free;

    // clamp config to the supported range
    assign sets_eff = (r_sets_log2 > 4'(SETS_LG)) ? 4'(SETS_LG) : r_sets_log2;
    always_comb begin
        if (r_ways_used == '0) begin
            ways_eff = C_WAYS_W'(1);
        end else if (r_ways_used > C_WAYS_W'(C_MAX_WAYS)) begin
            ways_eff = C_WAYS_W'(C_MAX_WAYS);
        end else begin
            ways_eff = r_ways_used;
        end
    end

    // split the address into set index and tag
    assign word_addr  = C_WORD_W'(i_s_tdata / C_BYTES_PER_WORD);
    assign block_addr = word_addr >> r_block_words_log2;
    assign set_mask   = (C_WORD_W'(1) << sets_eff) - C_WORD_W'(1);
    assign set_idx    = SET_W'(block_addr & set_mask);
    assign tag_val    = C_TAG_W'(block_addr >> sets_eff);

    // set-row store: valid, tag and rank of every way
    sacl_ram #(
        .WIDTH (C_ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (done),
        .i_waddr (r_set),
        .i_wdata (C_ROW_W'(row_out)),
        .i_re    (accept),
        .i_raddr (set_idx),
        .o_rdata (ram_rdata)
    );

    // a row never written reads as empty
    assign row_in = r_row_live ? t_set_row'(ram_rdata) : t_set_row'('0);

    sacl_set_update u_update (
        .i_row  (row_in),
        .i_tag  (r_tag),
        .i_ways (ways_eff),
        .o_res  (res),
        .o_row  (row_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        if (done) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    // control state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= ST_IDLE;
            r_m_valid          <= 1'b0;
            r_row_vld          <= '0;
            r_sets_log2        <= 4'd6;
            r_block_words_log2 <= 3'd2;
            r_ways_used        <= C_WAYS_W'(8);
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (done) begin
                r_row_vld[r_set] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    C_CFG_SETS_LOG2:   r_sets_log2        <= i_cfg_wdata;
                    C_CFG_BLOCK_WORDS: r_block_words_log2 <= i_cfg_wdata[2:0];
                    C_CFG_WAYS_USED:   r_ways_used        <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set      <= set_idx;
            r_tag      <= tag_val;
            r_row_live <= r_row_vld[set_idx];
        end
        if (done) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(C_OUT_DATA_W - C_OUT_W - C_WAY_W){1'b0}}, r_res.way, r_res.outcome};

endmodule

`default_nettype wire

FILE: rtl/sacl_ram.sv
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sacl_set_update.sv
// way search and lru rank update for one cache set row
`timescale 1ns / 1ps
`default_nettype none

module sacl_set_update
    import sacl_pkg::*;
(
    input  wire t_set_row            i_row,
    input  wire logic [C_TAG_W-1:0]  i_tag,
    input  wire logic [C_WAYS_W-1:0] i_ways,
    output t_lookup_res              o_res,
    output t_set_row                 o_row
);

    logic                hit_found;
    logic [C_WAY_W-1:0]  hit_way;
    logic                free_found;
    logic [C_WAY_W-1:0]  free_way;
    logic                vic_found;
    logic [C_WAY_W-1:0]  vic_way;
    logic [C_RANK_W-1:0] oldest;
    logic [C_WAY_W-1:0]  used_way;
    logic                fill;
    logic [C_RANK_W-1:0] old_rank;

    // search: highest matching tag, lowest free way, oldest valid way
    always_comb begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        vic_found  = 1'b0;
        vic_way    = '0;
        oldest     = '0;
        for (int i = 0; i < C_MAX_WAYS; i++) begin
            if (C_WAYS_W'(i) < i_ways) begin
                if (i_row[i].valid) begin
                    if (i_row[i].tag == i_tag) begin
                        hit_found = 1'b1;
                        hit_way   = C_WAY_W'(i);
                    end
                    if (!vic_found || i_row[i].rank > oldest) begin
                        vic_found = 1'b1;
                        vic_way   = C_WAY_W'(i);
                        oldest    = i_row[i].rank;
                    end
                end else if (!free_found) begin
                    free_found = 1'b1;
                    free_way   = C_WAY_W'(i);
                end
            end
        end
    end

    // pick the way and the outcome
    always_comb begin
        fill = 1'b0;
        if (hit_found) begin
            used_way      = hit_way;
            o_res.outcome = C_OUT_HIT;
        end else if (free_found) begin
            used_way      = free_way;
            fill          = 1'b1;
            o_res.outcome = C_OUT_FILL;
        end else begin
            used_way      = vic_way;
            o_res.outcome = C_OUT_REPLACE;
        end
        o_res.way = used_way;
        old_rank  = i_row[used_way].rank;
    end

    // age the younger ways (every valid way on a fill), make the used way most recent
    always_comb begin
        o_row = i_row;
        for (int i = 0; i < C_MAX_WAYS; i++) begin
            if ((C_WAYS_W'(i) < i_ways) && (C_WAY_W'(i) != used_way) && i_row[i].valid &&
                (fill || (i_row[i].rank < old_rank)) && (i_row[i].rank != C_MAX_RANK)) begin
                o_row[i].rank = i_row[i].rank + 1'b1;
            end
        end
        o_row[used_way].rank = '0;
        if (!hit_found) begin
            o_row[used_way].tag   = i_tag;
            o_row[used_way].valid = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sacl_checker.sv
// port-level checks of the lookup unit and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_cache_lru_lookup_unit_assert.svh"

module sacl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata
);

    // a pending result is held
    `SACL_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `SACL_ASSERT_NEXT(a_out_stable, o_m_tvalid && !i_m_tready, $stable(o_m_tdata))
    // one item in flight: no accept in the cycle after an accept
    `SACL_ASSERT_NEXT(a_one_inflight, i_s_tvalid && o_s_tready, !o_s_tready)
    // outcome code is one of hit, fill, replace and padding stays zero
    `SACL_ASSERT_SAME(a_outcome_code, o_m_tvalid, (o_m_tdata[1:0] != 2'd3) && (o_m_tdata[7:5] == 3'd0))

endmodule

bind set_assoc_cache_lru_lookup_unit sacl_checker u_sacl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
